// ----- design/slbm_pkg.sv -----
// shared types and constants for the serial loaded bank mapper
// no dependencies; imported by every module of the block
package slbm_pkg;

	localparam int PRG_ADDR_BITS = 19;
	localparam int CHR_ADDR_BITS = 17;
	localparam int PRG_BANK_SHIFT = 14;
	localparam int CHR_BANK_SHIFT = 12;

	localparam int ADDR_W = 16;
	localparam int DATA_W = 8;
	localparam int MAPPED_W = 19;
	localparam int BANK_W = 5;
	localparam int UNIT_W = 6;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 20;
	localparam int STEP_CNT_W = 3;

	localparam logic [UNIT_W-1:0] PRG_MIN_UNITS = UNIT_W'(1);
	localparam logic [UNIT_W-1:0] PRG_TOP_UNITS =
		UNIT_W'(1 << (PRG_ADDR_BITS - PRG_BANK_SHIFT));
	localparam logic [UNIT_W-1:0] CHR_MIN_UNITS = UNIT_W'(2);
	localparam logic [UNIT_W-1:0] CHR_TOP_UNITS =
		UNIT_W'(1 << (CHR_ADDR_BITS - CHR_BANK_SHIFT));
	localparam logic [UNIT_W-1:0] PRG_RESET_UNITS = UNIT_W'(262144 >> PRG_BANK_SHIFT);
	localparam logic [UNIT_W-1:0] CHR_RESET_UNITS = UNIT_W'(131072 >> CHR_BANK_SHIFT);

	localparam logic [BANK_W-1:0] CTRL_RESET = 5'h0C;
	localparam logic [BANK_W-1:0] CTRL_PRG_FORCE = 5'h0C;
	localparam logic [BANK_W-1:0] BANK_EVEN_MASK = 5'h1E;
	localparam logic [STEP_CNT_W-1:0] LAST_STEP = STEP_CNT_W'(BANK_W - 1);
	localparam logic [STEP_CNT_W-1:0] LOAD_COUNT = STEP_CNT_W'(5);

	localparam logic [CFG_IDX_W-1:0] CFG_PRG_ROM = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CHR_ROM = 2'd1;

	typedef enum logic [1:0] {
		ACT_CPU_WRITE = 2'd0,
		ACT_CPU_XLATE = 2'd1,
		ACT_PPU_XLATE = 2'd2,
		ACT_NONE      = 2'd3
	} slbm_action_t;

	typedef enum logic [1:0] {
		REG_CONTROL  = 2'd0,
		REG_CHR_LOW  = 2'd1,
		REG_CHR_HIGH = 2'd2,
		REG_PRG_BANK = 2'd3
	} slbm_reg_t;

	typedef enum logic [1:0] {
		OP_PRG    = 2'd0,
		OP_CHR_LO = 2'd1,
		OP_CHR_HI = 2'd2
	} slbm_op_t;

	typedef struct packed {
		logic     idle;
		logic     mod_load;
		logic     mod_step;
		logic     capture;
		logic     commit;
		slbm_op_t sel;
	} slbm_cmd_t;

	typedef struct packed {
		logic recalc_req;
	} slbm_sts_t;

endpackage

// ----- design/serial_loaded_bank_mapper_top.sv -----
// Serial loaded bank mapper, top level.
// Input stream: s_tuser carries the access kind (CPU write, CPU translate,
// PPU translate), s_tdata the bus address and the written byte. Every
// accepted word yields exactly one result word on the m_ side: the ROM byte
// offset, the nametable mirroring and an out-of-window flag.
// Configuration: cfg_index 0 writes the PRG ROM size, 1 the CHR ROM size;
// other indexes are ignored. Writes are taken while the mapper is idle.
// A result is registered when its input is accepted. Translations and
// writes that load no register run at one word per cycle while the receiver
// takes results and no configuration write is pending. A write that loads a
// register (fifth serial bit, or serial reset) or a configuration write
// starts a bank offset recompute: three remainders of a bank number by the
// ROM size, each a load, five steps and a capture on one shared serial
// remainder unit, then a commit; throughout, s_tready and cfg_ready are low.
// After reset the same recompute runs before the first word is taken.
// When the receiver stalls, the result is held in the output register and
// s_tready stays low until it is taken or taken in the same cycle.
// Depends on slbm_pkg, slbm_ctrl, slbm_dp and slbm_rem.
module serial_loaded_bank_mapper_top
	import slbm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [23:0]           s_tdata,   // address[15:0], data[23:16]
	input  logic [1:0]            s_tuser,   // action[1:0]
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [23:0]           m_tdata,   // mapped_address[18:0], mirror_mode[20:19],
	                                         // out_of_range[21], zero[23:22]
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	slbm_cmd_t cmd;
	slbm_sts_t sts;
	logic      in_accept;
	logic      cfg_accept;

	assign s_tready = cmd.idle && !cfg_valid && (!m_tvalid || m_tready);
	assign cfg_ready = cmd.idle;
	assign in_accept = s_tvalid && s_tready;
	assign cfg_accept = cfg_valid && cfg_ready;

	slbm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	slbm_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_accept  (in_accept),
		.in_action  (s_tuser),
		.in_address (s_tdata[15:0]),
		.in_data    (s_tdata[23:16]),
		.cfg_accept (cfg_accept),
		.cfg_idx    (cfg_index),
		.cfg_wdata  (cfg_data),
		.out_ready  (m_tready),
		.out_valid  (m_tvalid),
		.out_word   (m_tdata)
	);

endmodule

// ----- design/slbm_rem.sv -----
// serial remainder unit: five-bit bank number modulo a six-bit rom size in banks
// one quotient bit per cycle; uses slbm_pkg
module slbm_rem
	import slbm_pkg::*;
(
	input  logic              clk,
	input  logic              load,
	input  logic              step,
	input  logic [BANK_W-1:0] dividend,
	input  logic [UNIT_W-1:0] divisor,
	output logic [BANK_W-1:0] remainder
);

	logic [BANK_W-1:0] dvd_q;
	logic [BANK_W-1:0] rem_q;
	logic [UNIT_W-1:0] trial;

	assign trial = {rem_q, dvd_q[BANK_W-1]};
	assign remainder = rem_q;

	always_ff @(posedge clk) begin
		if (load) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (step) begin
			dvd_q <= {dvd_q[BANK_W-2:0], 1'b0};
			if (trial >= divisor) begin
				rem_q <= BANK_W'(trial - divisor);
			end else begin
				rem_q <= trial[BANK_W-1:0];
			end
		end
	end

endmodule

// ----- design/slbm_ctrl.sv -----
// controller: sequences the bank offset recompute over the remainder unit
// uses slbm_pkg; drives the datapath through slbm_cmd_t
module slbm_ctrl
	import slbm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  slbm_sts_t sts,
	output slbm_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_STEP,
		ST_CAPTURE,
		ST_COMMIT
	} state_t;

	state_t                state_q;
	slbm_op_t              sel_q;
	logic [STEP_CNT_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			sel_q <= OP_PRG;
			cnt_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (sts.recalc_req) begin
						state_q <= ST_LOAD;
						sel_q <= OP_PRG;
					end
				end
				ST_LOAD: begin
					cnt_q <= '0;
					state_q <= ST_STEP;
				end
				ST_STEP: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST_STEP) begin
						state_q <= ST_CAPTURE;
					end
				end
				ST_CAPTURE: begin
					unique case (sel_q)
						OP_PRG: begin
							sel_q <= OP_CHR_LO;
							state_q <= ST_LOAD;
						end
						OP_CHR_LO: begin
							sel_q <= OP_CHR_HI;
							state_q <= ST_LOAD;
						end
						default: begin
							state_q <= ST_COMMIT;
						end
					endcase
				end
				ST_COMMIT: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		cmd.idle = (state_q == ST_IDLE);
		cmd.mod_load = (state_q == ST_LOAD);
		cmd.mod_step = (state_q == ST_STEP);
		cmd.capture = (state_q == ST_CAPTURE);
		cmd.commit = (state_q == ST_COMMIT);
		cmd.sel = sel_q;
	end

endmodule

// ----- design/slbm_dp.sv -----
// datapath: serial loader, bank registers, rom sizes, offsets, translation, output word
// uses slbm_pkg and slbm_rem; controlled by slbm_ctrl
module slbm_dp
	import slbm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  slbm_cmd_t             cmd,
	output slbm_sts_t             sts,
	input  logic                  in_accept,
	input  logic [1:0]            in_action,
	input  logic [ADDR_W-1:0]     in_address,
	input  logic [DATA_W-1:0]     in_data,
	input  logic                  cfg_accept,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  out_ready,
	output logic                  out_valid,
	output logic [23:0]           out_word
);

	logic [BANK_W-1:0] shift_q, shift_d;
	logic [STEP_CNT_W-1:0] cnt_q, cnt_d;
	logic [BANK_W-1:0] ctrl_q, ctrl_d;
	logic [BANK_W-1:0] chr_lo_q, chr_lo_d;
	logic [BANK_W-1:0] chr_hi_q, chr_hi_d;
	logic [BANK_W-1:0] prg_bank_q, prg_bank_d;
	logic [UNIT_W-1:0] prg_units_q, chr_units_q;
	logic [UNIT_W-1:0] prg_units_new, chr_units_new;
	logic [BANK_W-1:0] prg_off_q [2];
	logic [BANK_W-1:0] chr_off_q [2];
	logic [BANK_W-1:0] res_prg_q, res_lo_q, res_hi_q;
	logic              out_valid_q;
	logic [23:0]       out_word_q;
	logic              write_recalc;
	logic [BANK_W-1:0] shifted;
	logic [BANK_W-1:0] operand;
	logic [UNIT_W-1:0] divisor;
	logic [BANK_W-1:0] remainder;
	logic [MAPPED_W-1:0] mapped;
	logic              oor;
	slbm_action_t      action;

	assign action = slbm_action_t'(in_action);
	assign shifted = {in_data[0], shift_q[BANK_W-1:1]};

	function automatic logic [BANK_W-1:0] inc_wrap(input logic [BANK_W-1:0] r,
			input logic [UNIT_W-1:0] units);
		logic [UNIT_W-1:0] n;
		n = {1'b0, r} + 1'b1;
		if (n == units) begin
			return '0;
		end
		return n[BANK_W-1:0];
	endfunction

	// serial loader
	always_comb begin
		shift_d = shift_q;
		cnt_d = cnt_q;
		ctrl_d = ctrl_q;
		chr_lo_d = chr_lo_q;
		chr_hi_d = chr_hi_q;
		prg_bank_d = prg_bank_q;
		write_recalc = 1'b0;
		if (in_accept && action == ACT_CPU_WRITE && in_address[15]) begin
			if (in_data[7]) begin
				shift_d = '0;
				cnt_d = '0;
				ctrl_d = ctrl_q | CTRL_PRG_FORCE;
				write_recalc = 1'b1;
			end else if (cnt_q + 1'b1 == LOAD_COUNT) begin
				shift_d = '0;
				cnt_d = '0;
				write_recalc = 1'b1;
				unique case (slbm_reg_t'(in_address[14:13]))
					REG_CONTROL: ctrl_d = shifted;
					REG_CHR_LOW: chr_lo_d = shifted;
					REG_CHR_HIGH: chr_hi_d = shifted;
					default: prg_bank_d = shifted;
				endcase
			end else begin
				shift_d = shifted;
				cnt_d = cnt_q + 1'b1;
			end
		end
	end

	assign sts.recalc_req = write_recalc || cfg_accept;

	// rom sizes in banks, rounded down and clamped (CHR sizes use cfg_data bits 17:12 only)
	always_comb begin
		prg_units_new = cfg_wdata[PRG_BANK_SHIFT +: UNIT_W];
		if (prg_units_new < PRG_MIN_UNITS) begin
			prg_units_new = PRG_MIN_UNITS;
		end else if (prg_units_new > PRG_TOP_UNITS) begin
			prg_units_new = PRG_TOP_UNITS;
		end
		chr_units_new = cfg_wdata[CHR_BANK_SHIFT +: UNIT_W];
		if (chr_units_new < CHR_MIN_UNITS) begin
			chr_units_new = CHR_MIN_UNITS;
		end else if (chr_units_new > CHR_TOP_UNITS) begin
			chr_units_new = CHR_TOP_UNITS;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= '0;
			cnt_q <= '0;
			ctrl_q <= CTRL_RESET;
			chr_lo_q <= '0;
			chr_hi_q <= '0;
			prg_bank_q <= '0;
			prg_units_q <= PRG_RESET_UNITS;
			chr_units_q <= CHR_RESET_UNITS;
			out_valid_q <= 1'b0;
		end else begin
			shift_q <= shift_d;
			cnt_q <= cnt_d;
			ctrl_q <= ctrl_d;
			chr_lo_q <= chr_lo_d;
			chr_hi_q <= chr_hi_d;
			prg_bank_q <= prg_bank_d;
			if (cfg_accept && cfg_idx == CFG_PRG_ROM) begin
				prg_units_q <= prg_units_new;
			end
			if (cfg_accept && cfg_idx == CFG_CHR_ROM) begin
				chr_units_q <= chr_units_new;
			end
			if (in_accept) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// remainder operand selection
	always_comb begin
		unique case (cmd.sel)
			OP_PRG: begin
				operand = ctrl_q[3] ? prg_bank_q : (prg_bank_q & BANK_EVEN_MASK);
				divisor = prg_units_q;
			end
			OP_CHR_LO: begin
				operand = ctrl_q[4] ? chr_lo_q : (chr_lo_q & BANK_EVEN_MASK);
				divisor = chr_units_q;
			end
			default: begin
				operand = chr_hi_q;
				divisor = chr_units_q;
			end
		endcase
	end

	slbm_rem u_rem (
		.clk       (clk),
		.load      (cmd.mod_load),
		.step      (cmd.mod_step),
		.dividend  (operand),
		.divisor   (divisor),
		.remainder (remainder)
	);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			unique case (cmd.sel)
				OP_PRG: res_prg_q <= remainder;
				OP_CHR_LO: res_lo_q <= remainder;
				default: res_hi_q <= remainder;
			endcase
		end
		if (cmd.commit) begin
			unique case (ctrl_q[3:2])
				2'd2: begin
					prg_off_q[0] <= '0;
					prg_off_q[1] <= res_prg_q;
				end
				2'd3: begin
					prg_off_q[0] <= res_prg_q;
					prg_off_q[1] <= BANK_W'(prg_units_q - 1'b1);
				end
				default: begin
					prg_off_q[0] <= res_prg_q;
					prg_off_q[1] <= inc_wrap(res_prg_q, prg_units_q);
				end
			endcase
			chr_off_q[0] <= res_lo_q;
			chr_off_q[1] <= ctrl_q[4] ? res_hi_q : inc_wrap(res_lo_q, chr_units_q);
		end
		if (in_accept) begin
			out_word_q <= {2'b00, oor, ctrl_d[1:0], mapped};
		end
	end

	// translation
	always_comb begin
		mapped = '0;
		oor = 1'b0;
		unique case (action)
			ACT_CPU_WRITE: begin
				oor = 1'b0;
			end
			ACT_CPU_XLATE: begin
				if (!in_address[15]) begin
					oor = 1'b1;
				end else begin
					mapped = {prg_off_q[in_address[14]], in_address[13:0]};
				end
			end
			ACT_PPU_XLATE: begin
				if (in_address[15:13] != 3'b000) begin
					oor = 1'b1;
				end else begin
					mapped = MAPPED_W'({chr_off_q[in_address[12]], in_address[11:0]});
				end
			end
			default: begin
				oor = 1'b1;
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_word = out_word_q;

endmodule
